>>> hdl/led_bar_graph_matrix_driver_core_macros.svh
// assertion macros for the led bar graph matrix driver core
// expects clk and rst in scope at the point of use
`ifndef LED_BAR_GRAPH_MATRIX_DRIVER_CORE_MACROS_SVH
`define LED_BAR_GRAPH_MATRIX_DRIVER_CORE_MACROS_SVH

// same-cycle implication
`define LBG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LBG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/lbg_pkg.sv
// shared types, constants and the level quantizer for the led bar graph driver
// no dependencies
package lbg_pkg;

  localparam int NUM_ROWS_DEF = 4;
  localparam int NUM_COLS_DEF = 10;

  localparam int BYTE_W = 8;
  localparam int ROW_DRIVE_W = 4;
  localparam int COL_DRIVE_W = 10;

  // width of a quantized level pattern before masking to the column count
  localparam int BAR_W = 10;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  localparam logic [BYTE_W-1:0] PTR_RESET = 8'd255;
  localparam logic [BYTE_W-1:0] LEVEL_MAX = 8'd100;
  localparam int LEVEL_STEP = 10;
  localparam logic [BAR_W-1:0] ERR_PATTERN = 10'h055;

  // decoded work for one beat as it leaves the input register
  typedef struct packed {
    logic tick;
    logic load;
    logic ptr_clr;
  } lbg_step_t;

  // thermometer code of ceil(b/10) for 1..100, empty for 0, error above 100
  function automatic logic [BAR_W-1:0] quantize(input logic [BYTE_W-1:0] b);
    logic [BAR_W-1:0] p;
    p = '0;
    if (b > LEVEL_MAX) begin
      p = ERR_PATTERN;
    end else begin
      for (int i = 0; i < BAR_W; i++) begin
        p[i] = (b > BYTE_W'(i * LEVEL_STEP));
      end
    end
    return p;
  endfunction

endpackage

>>> hdl/lbg_item_if.sv
// input channel of the led bar graph driver: scan tick or level byte
// depends on lbg_pkg
interface lbg_item_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [lbg_pkg::BYTE_W-1:0]  byte_value;

  modport source (output valid, output op, output byte_value, input ready);
  modport sink (input valid, input op, input byte_value, output ready);
endinterface

>>> hdl/lbg_result_if.sv
// result channel of the led bar graph driver: row and column drives
// depends on lbg_pkg
interface lbg_result_if;
  logic                             valid;
  logic                             ready;
  logic [lbg_pkg::ROW_DRIVE_W-1:0]  row_drive;
  logic [lbg_pkg::COL_DRIVE_W-1:0]  col_drive;

  modport source (output valid, output row_drive, output col_drive, input ready);
  modport sink (input valid, input row_drive, input col_drive, output ready);
endinterface

>>> hdl/lbg_bar_store.sv
// bar pattern store with saturating write pointer and quantizer on the write side
// depends on lbg_pkg
module lbg_bar_store #(
  parameter int NUM_ROWS = lbg_pkg::NUM_ROWS_DEF,
  parameter int NUM_COLS = lbg_pkg::NUM_COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lbg_pkg::lbg_step_t            step,
  input  logic [lbg_pkg::BYTE_W-1:0]    byte_value,
  input  logic [$clog2(NUM_ROWS)-1:0]   rd_row,
  output logic [NUM_COLS-1:0]           rd_data
);

  localparam int RW = $clog2(NUM_ROWS);
  localparam int PW = $clog2(NUM_ROWS + 1);

  logic [NUM_COLS-1:0] bars [NUM_ROWS];
  logic [PW-1:0]       wr_ptr;
  logic [NUM_COLS+lbg_pkg::BAR_W-1:0] pat_wide;
  logic [NUM_COLS-1:0] pat;
  logic                wr_en;

  // pad then cut so any column count works
  assign pat_wide = {{NUM_COLS{1'b0}}, lbg_pkg::quantize(byte_value)};
  assign pat      = pat_wide[NUM_COLS-1:0];
  assign wr_en    = step.load && (wr_ptr < PW'(NUM_ROWS));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      for (int i = 0; i < NUM_ROWS; i++) begin
        bars[i] <= '0;
      end
    end else begin
      if (step.ptr_clr) begin
        wr_ptr <= '0;
      end else if (wr_en) begin
        bars[wr_ptr[RW-1:0]] <= pat;
        wr_ptr               <= wr_ptr + PW'(1);
      end
    end
  end

  assign rd_data = bars[rd_row];

endmodule

>>> hdl/lbg_scan.sv
// row scanner: active row, column latch and the drive values after each beat
// depends on lbg_pkg
module lbg_scan #(
  parameter int NUM_ROWS = lbg_pkg::NUM_ROWS_DEF,
  parameter int NUM_COLS = lbg_pkg::NUM_COLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lbg_pkg::lbg_step_t                step,
  output logic [$clog2(NUM_ROWS)-1:0]       rd_row,
  input  logic [NUM_COLS-1:0]               rd_data,
  output logic [lbg_pkg::ROW_DRIVE_W-1:0]   row_drive,
  output logic [lbg_pkg::COL_DRIVE_W-1:0]   col_drive
);

  localparam int RW = $clog2(NUM_ROWS);

  logic [RW-1:0]       scan_row;
  logic [RW-1:0]       scan_row_next;
  logic                rows_on;
  logic                rows_on_next;
  logic [NUM_COLS-1:0] latched;
  logic [NUM_COLS-1:0] latched_next;
  logic [NUM_COLS+lbg_pkg::COL_DRIVE_W-1:0] cols_wide;

  // the tick reads the row it is about to show
  assign rd_row = (scan_row == RW'(NUM_ROWS - 1)) ? '0 : scan_row + RW'(1);

  always_comb begin
    scan_row_next = scan_row;
    rows_on_next  = rows_on;
    latched_next  = latched;
    if (step.tick) begin
      scan_row_next = rd_row;
      rows_on_next  = 1'b1;
      latched_next  = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row <= '0;
      rows_on  <= 1'b0;
      latched  <= '0;
    end else begin
      scan_row <= scan_row_next;
      rows_on  <= rows_on_next;
      latched  <= latched_next;
    end
  end

  // drives as they stand once this beat is applied
  always_comb begin
    for (int i = 0; i < lbg_pkg::ROW_DRIVE_W; i++) begin
      row_drive[i] = rows_on_next && (32'(scan_row_next) == 32'(i));
    end
  end

  assign cols_wide = {{lbg_pkg::COL_DRIVE_W{1'b0}}, (rows_on_next ? latched_next : '0)};
  assign col_drive = cols_wide[lbg_pkg::COL_DRIVE_W-1:0];

endmodule

>>> hdl/led_bar_graph_matrix_driver_core.sv
// top level of the multiplexed led bar graph driver
// depends on lbg_pkg, lbg_item_if, lbg_result_if, lbg_bar_store, lbg_scan and the macros header
`include "led_bar_graph_matrix_driver_core_macros.svh"

// Drives a NUM_ROWS by NUM_COLS multiplexed LED bar display. Each beat on item is
// a scan tick (op 0) or a level byte (op 1); every beat gives exactly one beat on
// result with the row and column drives as they stand after that beat. One beat
// is taken per clock when result is not stalled; each beat passes through the input
// register and then the result register, with the state update and level
// quantizer between them. Ready on item follows ready on result combinationally
// when both registers are full. The bar store is cleared by reset, no sweep.
module led_bar_graph_matrix_driver_core #(
  parameter int NUM_ROWS = lbg_pkg::NUM_ROWS_DEF,
  parameter int NUM_COLS = lbg_pkg::NUM_COLS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  lbg_item_if.sink      item,
  lbg_result_if.source  result
);

  localparam int RW = $clog2(NUM_ROWS);

  logic                            s0_valid;
  logic                            s0_op;
  logic [lbg_pkg::BYTE_W-1:0]      s0_byte;
  logic                            s1_valid;
  logic                            s1_free;
  logic                            adv;
  lbg_pkg::lbg_step_t              step;
  logic [RW-1:0]                   rd_row;
  logic [NUM_COLS-1:0]             rd_data;
  logic [lbg_pkg::ROW_DRIVE_W-1:0] row_drive_next;
  logic [lbg_pkg::COL_DRIVE_W-1:0] col_drive_next;
  logic [lbg_pkg::ROW_DRIVE_W-1:0] row_drive;
  logic [lbg_pkg::COL_DRIVE_W-1:0] col_drive;

  assign s1_free    = !s1_valid || result.ready;
  assign item.ready = !s0_valid || s1_free;
  assign adv        = s0_valid && s1_free;

  always_comb begin
    step.tick    = adv && (s0_op == lbg_pkg::OP_TICK);
    step.ptr_clr = adv && (s0_op == lbg_pkg::OP_BYTE) && (s0_byte == lbg_pkg::PTR_RESET);
    step.load    = adv && (s0_op == lbg_pkg::OP_BYTE) && (s0_byte != lbg_pkg::PTR_RESET);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (item.ready) begin
        s0_valid <= item.valid;
      end
      if (s1_free) begin
        s1_valid <= s0_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s0_op   <= item.op;
      s0_byte <= item.byte_value;
    end
    if (adv) begin
      row_drive <= row_drive_next;
      col_drive <= col_drive_next;
    end
  end

  lbg_bar_store #(
    .NUM_ROWS (NUM_ROWS),
    .NUM_COLS (NUM_COLS)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .byte_value (s0_byte),
    .rd_row     (rd_row),
    .rd_data    (rd_data)
  );

  lbg_scan #(
    .NUM_ROWS (NUM_ROWS),
    .NUM_COLS (NUM_COLS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rd_row    (rd_row),
    .rd_data   (rd_data),
    .row_drive (row_drive_next),
    .col_drive (col_drive_next)
  );

  assign result.valid     = s1_valid;
  assign result.row_drive = row_drive;
  assign result.col_drive = col_drive;

  `LBG_ASSERT_NOW(a_row_onehot, result.valid, $onehot0(result.row_drive), "row drive not one-hot")
  `LBG_ASSERT_NEXT(a_s0_hold, s0_valid && !s1_free, s0_valid && $stable(s0_op) && $stable(s0_byte), "input register lost a stalled beat")
  `LBG_ASSERT_NEXT(a_adv_result, adv, result.valid, "advanced beat missing at result")

endmodule

>>> tb/lbg_drive_checker.sv
`timescale 1ns / 1ps
// scoreboard for the led bar graph driver: tracks bars, pointer and scan row
// per item beat, then compares each result beat; depends on lbg_pkg and both interfaces
module lbg_drive_checker #(
  parameter int NUM_ROWS = lbg_pkg::NUM_ROWS_DEF,
  parameter int NUM_COLS = lbg_pkg::NUM_COLS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  lbg_item_if    item,
  lbg_result_if  result,
  output int     errors,
  output int     pending
);

  localparam int BYTE_W      = lbg_pkg::BYTE_W;
  localparam int ROW_DRIVE_W = lbg_pkg::ROW_DRIVE_W;
  localparam int COL_DRIVE_W = lbg_pkg::COL_DRIVE_W;
  localparam int LEVEL_STEP  = lbg_pkg::LEVEL_STEP;
  localparam logic [BYTE_W-1:0] LEVEL_MAX = lbg_pkg::LEVEL_MAX;
  localparam logic [BYTE_W-1:0] PTR_RESET = lbg_pkg::PTR_RESET;
  localparam logic [lbg_pkg::BAR_W-1:0] ERR_PATTERN = lbg_pkg::ERR_PATTERN;
  localparam logic OP_TICK = lbg_pkg::OP_TICK;

  typedef struct packed {
    logic [ROW_DRIVE_W-1:0] row;
    logic [COL_DRIVE_W-1:0] col;
  } drive_t;

  logic [NUM_COLS-1:0] bars [NUM_ROWS];
  int unsigned         wr_col;
  int unsigned         row_sel;
  logic                lit;
  logic [NUM_COLS-1:0] shown;
  drive_t              drive_q [$];

  // thermometer of ceil(b/10) lit leds, error pattern above full scale
  function automatic logic [NUM_COLS-1:0] level_bars(input logic [BYTE_W-1:0] b);
    int n;
    if (b == '0) return '0;
    if (b > LEVEL_MAX) return NUM_COLS'(ERR_PATTERN);
    n = (int'(b) + LEVEL_STEP - 1) / LEVEL_STEP;
    return NUM_COLS'((64'd1 << n) - 64'd1);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch, got 'h%0h expected 'h%0h", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    drive_t got;
    drive_t want;
    drive_t next_drive;
    if (rst) begin
      foreach (bars[i]) bars[i] = '0;
      wr_col  = 0;
      row_sel = 0;
      lit     = 1'b0;
      shown   = '0;
      drive_q.delete();
    end else begin
      // compare first so a stray result beat is never matched to this edge's item
      if (result.valid && result.ready) begin
        got.row = result.row_drive;
        got.col = result.col_drive;
        if (drive_q.size() == 0) begin
          report_mismatch("unexpected result beat", got, 0);
        end else begin
          want = drive_q.pop_front();
          if (got.row !== want.row) report_mismatch("row_drive", got.row, want.row);
          if (got.col !== want.col) report_mismatch("col_drive", got.col, want.col);
        end
      end
      if (item.valid && item.ready) begin
        if (item.op == OP_TICK) begin
          row_sel = (row_sel + 1) % NUM_ROWS;
          shown   = bars[row_sel];
          lit     = 1'b1;
        end else if (item.byte_value == PTR_RESET) begin
          wr_col = 0;
        end else if (wr_col < NUM_ROWS) begin
          // pointer saturates past the last bar until the next pointer reset
          bars[wr_col] = level_bars(item.byte_value);
          wr_col++;
        end
        next_drive.row = lit ? ROW_DRIVE_W'(64'd1 << row_sel) : '0;
        next_drive.col = lit ? COL_DRIVE_W'(shown) : '0;
        drive_q.push_back(next_drive);
      end
    end
    pending <= drive_q.size();
  end

endmodule

>>> tb/tb_led_bar_graph_matrix_driver_core.sv
`timescale 1ns / 1ps
// top of the led bar graph driver testbench: clock, reset, stimulus, verdict
// depends on lbg_pkg, both interfaces, lbg_drive_checker and the driver core
module tb_led_bar_graph_matrix_driver_core;

  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_BEATS = 165;

  localparam int BYTE_W = lbg_pkg::BYTE_W;
  localparam logic OP_TICK = lbg_pkg::OP_TICK;
  localparam logic OP_BYTE = lbg_pkg::OP_BYTE;
  localparam logic [BYTE_W-1:0] PTR_RESET = lbg_pkg::PTR_RESET;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   stalled_cycles;

  lbg_item_if   item_ch ();
  lbg_result_if result_ch ();

  led_bar_graph_matrix_driver_core dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  lbg_drive_checker checker_i (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk                  = 1'b0;
    rst                  = 1'b1;
    item_ch.valid        = 1'b0;
    item_ch.op           = OP_TICK;
    item_ch.byte_value   = '0;
    result_ch.ready      = 1'b0;
    send_idle_pct        = 0;
    recv_idle_pct        = 0;
    stalled_cycles       = 0;
  end

  always #4 clk = ~clk;

  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // valid stays high across back-to-back beats, only one update per edge
  task automatic send_beat(input logic op, input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.op         <= op;
    item_ch.byte_value <= b;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [BYTE_W-1:0] random_level();
    int r;
    r = $urandom_range(9);
    if (r < 6) return BYTE_W'($urandom_range(100, 0));
    if (r < 8) return BYTE_W'($urandom_range(254, 101));
    return BYTE_W'($urandom_range(254, 0));
  endfunction

  // pointer reset, a few levels (a fifth one overruns the bars), then some ticks
  task automatic send_frame(inout int beats);
    int n_levels;
    int n_ticks;
    n_levels = $urandom_range(5, 1);
    n_ticks  = $urandom_range(6, 1);
    send_beat(OP_BYTE, PTR_RESET);
    repeat (n_levels) send_beat(OP_BYTE, random_level());
    repeat (n_ticks) send_beat(OP_TICK, BYTE_W'($urandom));
    beats += 1 + n_levels + n_ticks;
  endtask

  task automatic send_noise(inout int beats);
    int n;
    n = $urandom_range(4, 1);
    repeat (n) send_beat(1'($urandom), BYTE_W'($urandom_range(255, 0)));
    beats += n;
  endtask

  logic [BYTE_W:0] directed [20] = '{
    {OP_BYTE, 8'd0},   {OP_BYTE, 8'd1},   {OP_BYTE, 8'd100}, {OP_BYTE, 8'd101},
    {OP_BYTE, 8'd50},  {OP_TICK, 8'd255}, {OP_TICK, 8'h5a},  {OP_TICK, 8'd0},
    {OP_TICK, 8'ha5},  {OP_BYTE, 8'd255}, {OP_BYTE, 8'd10},  {OP_BYTE, 8'd11},
    {OP_BYTE, 8'd91},  {OP_BYTE, 8'd254}, {OP_BYTE, 8'd255}, {OP_BYTE, 8'd9},
    {OP_TICK, 8'h0f},  {OP_TICK, 8'hf0},  {OP_TICK, 8'h33},  {OP_TICK, 8'hcc}
  };

  initial begin
    int beats;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 70 : 0;
      recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 10 : 0;
      // empty display, bar overrun, first tick, row wrap and pointer reset up front
      if (phase == 0) begin
        foreach (directed[i]) send_beat(directed[i][BYTE_W], directed[i][BYTE_W-1:0]);
      end
      beats = 0;
      while (beats < PHASE_BEATS) begin
        if ($urandom_range(7) == 0) send_noise(beats);
        else send_frame(beats);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
